[rtl/oipv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oipv_pkg
// Shared types, constants and the CRC-32 byte step of the package validator.
// ----------------------------------------------------------------------------
package oipv_pkg;

  localparam int unsigned HDR_BYTES   = 32;
  localparam int unsigned HDR_IDX_W   = $clog2(HDR_BYTES);
  localparam int unsigned HDR_CRC_END = 28;
  localparam int unsigned COUNT_W     = 34;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned MAGIC_BYTES = 8;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [15:0] FORMAT_VERSION = 16'h0001;

  localparam logic [7:0] MAGIC [MAGIC_BYTES] = '{
    8'h57, 8'h4B, 8'h52, 8'h50, 8'h4F, 8'h54, 8'h41, 8'h31
  };

  // configuration reset values
  localparam logic [7:0]  RST_TARGET     = 8'h01;
  localparam logic [7:0]  RST_PROTOCOL   = 8'h01;
  localparam logic [15:0] RST_BOARD      = 16'h2040;
  localparam logic [15:0] RST_VEC_OFFSET = 16'h0100;
  localparam logic [31:0] RST_STACK_LOW  = 32'h2000_0000;
  localparam logic [31:0] RST_STACK_HIGH = 32'h2004_2000;
  localparam logic [31:0] RST_CODE_LOW   = 32'h1000_0000;
  localparam logic [31:0] RST_CODE_HIGH  = 32'h1020_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET     = 3'd0,
    CFG_PROTOCOL   = 3'd1,
    CFG_BOARD      = 3'd2,
    CFG_VEC_OFFSET = 3'd3,
    CFG_STACK_LOW  = 3'd4,
    CFG_STACK_HIGH = 3'd5,
    CFG_CODE_LOW   = 3'd6,
    CFG_CODE_HIGH  = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    VERDICT_OK      = 4'd0,
    VERDICT_SHORT   = 4'd1,
    VERDICT_MAGIC   = 4'd2,
    VERDICT_FIELD   = 4'd3,
    VERDICT_HDR_CRC = 4'd4,
    VERDICT_SIZE    = 4'd5,
    VERDICT_PAY_CRC = 4'd6,
    VERDICT_NO_VEC  = 4'd7,
    VERDICT_BAD_VEC = 4'd8
  } verdict_e;

  typedef struct packed {
    logic [7:0]  target;
    logic [7:0]  protocol;
    logic [15:0] board;
    logic [15:0] vec_offset;
    logic [31:0] stack_low;
    logic [31:0] stack_high;
    logic [31:0] code_low;
    logic [31:0] code_high;
  } cfg_t;

  // snapshot of the stream state after the final byte
  typedef struct packed {
    logic [COUNT_W-1:0]             total;
    logic [HDR_BYTES-1:0][7:0]      hdr;
    logic [31:0]                    hdr_crc;
    logic [31:0]                    pay_crc;
    logic [31:0]                    stack_word;
    logic [31:0]                    handler_word;
  } rec_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [31:0] length;
    logic [31:0] checksum;
  } res_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

[rtl/oipv_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oipv_queue
// Small register-based first-in first-out queue with count-based flags.
// ----------------------------------------------------------------------------
module oipv_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/oipv_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oipv_front
// Byte intake: counts bytes, keeps the header, runs both CRCs and captures
// the vector words; hands a snapshot of the stream on each final byte.
// ----------------------------------------------------------------------------
module oipv_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          package_byte_i,
  input  logic                final_byte_i,
  input  logic [15:0]         vec_offset_i,
  output logic                rec_push_o,
  output oipv_pkg::rec_t      rec_o
);
  import oipv_pkg::*;

  logic [COUNT_W-1:0]        count_q, count_d;
  logic [HDR_BYTES-1:0][7:0] hdr_q, hdr_d;
  logic [31:0]               hcrc_q, hcrc_d;
  logic [31:0]               pcrc_q, pcrc_d;
  logic [31:0]               stack_q, stack_d;
  logic [31:0]               handler_q, handler_d;
  logic [COUNT_W-1:0]        pay_pos, vec_diff;
  logic                      in_header, vec_hit;

  assign in_header = (count_q < COUNT_W'(HDR_BYTES));
  assign pay_pos   = count_q - COUNT_W'(HDR_BYTES);
  assign vec_diff  = pay_pos - COUNT_W'(vec_offset_i);
  assign vec_hit   = !in_header && (pay_pos >= COUNT_W'(vec_offset_i)) &&
                     (vec_diff < COUNT_W'(8));

  always_comb begin
    hdr_d     = hdr_q;
    hcrc_d    = hcrc_q;
    pcrc_d    = pcrc_q;
    stack_d   = stack_q;
    handler_d = handler_q;
    count_d   = (count_q != '1) ? count_q + 1'b1 : count_q;
    if (in_header) begin
      hdr_d[count_q[HDR_IDX_W-1:0]] = package_byte_i;
      if (count_q < COUNT_W'(HDR_CRC_END)) begin
        hcrc_d = crc_byte(hcrc_q, package_byte_i);
      end
    end else begin
      pcrc_d = crc_byte(pcrc_q, package_byte_i);
    end
    // vector words, little endian, stack word first
    if (vec_hit) begin
      if (!vec_diff[2]) begin
        stack_d[{vec_diff[1:0], 3'b000} +: 8] = package_byte_i;
      end else begin
        handler_d[{vec_diff[1:0], 3'b000} +: 8] = package_byte_i;
      end
    end
  end

  assign rec_push_o        = accept_i && final_byte_i;
  assign rec_o.total        = count_d;
  assign rec_o.hdr          = hdr_d;
  assign rec_o.hdr_crc      = hcrc_d;
  assign rec_o.pay_crc      = pcrc_d;
  assign rec_o.stack_word   = stack_d;
  assign rec_o.handler_word = handler_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      hcrc_q    <= CRC_INIT;
      pcrc_q    <= CRC_INIT;
      stack_q   <= '0;
      handler_q <= '0;
    end else if (accept_i) begin
      if (final_byte_i) begin
        count_q   <= '0;
        hcrc_q    <= CRC_INIT;
        pcrc_q    <= CRC_INIT;
        stack_q   <= '0;
        handler_q <= '0;
      end else begin
        count_q   <= count_d;
        hcrc_q    <= hcrc_d;
        pcrc_q    <= pcrc_d;
        stack_q   <= stack_d;
        handler_q <= handler_d;
      end
    end
  end

  // header bytes are always rewritten before a full-length package reads them
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      hdr_q <= hdr_d;
    end
  end

endmodule

[rtl/oipv_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oipv_back
// Verdict stage: runs the package checks in file order on one snapshot and
// forms the result beat.
// ----------------------------------------------------------------------------
module oipv_back (
  input  logic           rec_valid_i,
  input  oipv_pkg::rec_t rec_i,
  input  oipv_pkg::cfg_t cfg_i,
  input  logic           res_full_i,
  output logic           rec_pop_o,
  output logic           res_push_o,
  output oipv_pkg::res_t res_o
);
  import oipv_pkg::*;

  logic [15:0]        version, board, hdr_size;
  logic [31:0]        pay_size, pay_crc_field, vec_field, hdr_crc_field;
  logic [31:0]        hdr_crc, pay_crc, addr;
  logic [COUNT_W-1:0] pay_len;
  logic [COUNT_W:0]   want_total;
  logic               short_pkg, bad_magic, bad_field, bad_hcrc, bad_size;
  logic               bad_pcrc, no_vec, bad_vec;
  verdict_e           verdict;

  assign version       = {rec_i.hdr[9], rec_i.hdr[8]};
  assign board         = {rec_i.hdr[13], rec_i.hdr[12]};
  assign hdr_size      = {rec_i.hdr[15], rec_i.hdr[14]};
  assign pay_size      = {rec_i.hdr[19], rec_i.hdr[18], rec_i.hdr[17], rec_i.hdr[16]};
  assign pay_crc_field = {rec_i.hdr[23], rec_i.hdr[22], rec_i.hdr[21], rec_i.hdr[20]};
  assign vec_field     = {rec_i.hdr[27], rec_i.hdr[26], rec_i.hdr[25], rec_i.hdr[24]};
  assign hdr_crc_field = {rec_i.hdr[31], rec_i.hdr[30], rec_i.hdr[29], rec_i.hdr[28]};
  assign hdr_crc       = ~rec_i.hdr_crc;
  assign pay_crc       = ~rec_i.pay_crc;
  assign pay_len       = rec_i.total - COUNT_W'(HDR_BYTES);
  assign want_total    = (COUNT_W + 1)'(HDR_BYTES) + (COUNT_W + 1)'(pay_size);
  assign addr          = {rec_i.handler_word[31:1], 1'b0};

  always_comb begin
    bad_magic = 1'b0;
    for (int i = 0; i < MAGIC_BYTES; i++) begin
      if (rec_i.hdr[i] != MAGIC[i]) begin
        bad_magic = 1'b1;
      end
    end
  end

  assign short_pkg = (rec_i.total < COUNT_W'(HDR_BYTES));
  assign bad_field = (version != FORMAT_VERSION) || (hdr_size != 16'(HDR_BYTES)) ||
                     (rec_i.hdr[10] != cfg_i.target) ||
                     (rec_i.hdr[11] != cfg_i.protocol) || (board != cfg_i.board);
  assign bad_hcrc  = (hdr_crc != hdr_crc_field);
  assign bad_size  = ({1'b0, rec_i.total} != want_total);
  assign bad_pcrc  = (pay_crc != pay_crc_field);
  assign no_vec    = (vec_field != 32'(cfg_i.vec_offset)) ||
                     (pay_len < COUNT_W'(cfg_i.vec_offset) + COUNT_W'(8));
  assign bad_vec   = (rec_i.stack_word < cfg_i.stack_low) ||
                     (rec_i.stack_word > cfg_i.stack_high) ||
                     !rec_i.handler_word[0] ||
                     (addr < cfg_i.code_low) || (addr >= cfg_i.code_high);

  // first failing check wins
  always_comb begin
    if (short_pkg) begin
      verdict = VERDICT_SHORT;
    end else if (bad_magic) begin
      verdict = VERDICT_MAGIC;
    end else if (bad_field) begin
      verdict = VERDICT_FIELD;
    end else if (bad_hcrc) begin
      verdict = VERDICT_HDR_CRC;
    end else if (bad_size) begin
      verdict = VERDICT_SIZE;
    end else if (bad_pcrc) begin
      verdict = VERDICT_PAY_CRC;
    end else if (no_vec) begin
      verdict = VERDICT_NO_VEC;
    end else if (bad_vec) begin
      verdict = VERDICT_BAD_VEC;
    end else begin
      verdict = VERDICT_OK;
    end
  end

  assign res_o.verdict  = verdict;
  assign res_o.length   = short_pkg ? 32'h0 : pay_size;
  assign res_o.checksum = pay_crc;

  assign res_push_o = rec_valid_i && !res_full_i;
  assign rec_pop_o  = res_push_o;

endmodule

[rtl/ota_image_package_validator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ota_image_package_validator
// Streams a firmware package byte by byte and reports one verdict per package.
// ----------------------------------------------------------------------------
// result path: a final byte's snapshot is registered in the snapshot queue, then
//   its result beat in the result queue (when it has room) that drives the ports
// throughput: one byte per cycle, set by the byte-wide crc step, while full is low
// reset: asynchronous; configuration returns to defaults, byte count and crcs
//   clear, queues empty; the header store holds no value until written
module ota_image_package_validator #(
  parameter int unsigned QUEUE_DEPTH_P = oipv_pkg::QUEUE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic [7:0]                       package_byte_i,
  input  logic                             final_byte_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [3:0]                       verdict_o,
  output logic [31:0]                      payload_length_o,
  output logic [31:0]                      payload_checksum_o,
  input  logic                             cfg_we_i,
  input  logic [oipv_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [oipv_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import oipv_pkg::*;

  cfg_t cfg_q;
  rec_t rec_in, rec_head;
  res_t res_in, res_head;
  logic accept, rec_push, rec_pop, rec_empty, res_push, res_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target     <= RST_TARGET;
      cfg_q.protocol   <= RST_PROTOCOL;
      cfg_q.board      <= RST_BOARD;
      cfg_q.vec_offset <= RST_VEC_OFFSET;
      cfg_q.stack_low  <= RST_STACK_LOW;
      cfg_q.stack_high <= RST_STACK_HIGH;
      cfg_q.code_low   <= RST_CODE_LOW;
      cfg_q.code_high  <= RST_CODE_HIGH;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TARGET:     cfg_q.target     <= cfg_data_i[7:0];
        CFG_PROTOCOL:   cfg_q.protocol   <= cfg_data_i[7:0];
        CFG_BOARD:      cfg_q.board      <= cfg_data_i[15:0];
        CFG_VEC_OFFSET: cfg_q.vec_offset <= cfg_data_i[15:0];
        CFG_STACK_LOW:  cfg_q.stack_low  <= cfg_data_i;
        CFG_STACK_HIGH: cfg_q.stack_high <= cfg_data_i;
        CFG_CODE_LOW:   cfg_q.code_low   <= cfg_data_i;
        CFG_CODE_HIGH:  cfg_q.code_high  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign accept = push && !full;

  oipv_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .package_byte_i (package_byte_i),
    .final_byte_i   (final_byte_i),
    .vec_offset_i   (cfg_q.vec_offset),
    .rec_push_o     (rec_push),
    .rec_o          (rec_in)
  );

  oipv_queue #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (QUEUE_DEPTH_P)
  ) u_rec_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .data_i  (rec_in),
    .full_o  (full),
    .pop_i   (rec_pop),
    .data_o  (rec_head),
    .empty_o (rec_empty)
  );

  oipv_back u_back (
    .rec_valid_i (!rec_empty),
    .rec_i       (rec_head),
    .cfg_i       (cfg_q),
    .res_full_i  (res_full),
    .rec_pop_o   (rec_pop),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  oipv_queue #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH_P)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_head),
    .empty_o (empty)
  );

  assign verdict_o          = res_head.verdict;
  assign payload_length_o   = res_head.length;
  assign payload_checksum_o = res_head.checksum;

endmodule
